FILE: rtl/core/rfpa_pkg.sv
// ----------------------------------------------------------------------------
// rfpa_pkg
// Shared constants, color codes and types of the rainbow fill animator.
// ----------------------------------------------------------------------------
package rfpa_pkg;

    localparam int LED_COUNT       = 8;
    localparam int LED_IDX_W       = 3;
    localparam int CYCLES_W        = 4;
    localparam int HOLD_W          = 8;
    localparam int DELAY_W         = 16;
    localparam int TIME_W          = 32;
    localparam int CODE_W          = 4;
    localparam int RAINBOW_COLORS  = 7;
    localparam int CMD_QUEUE_DEPTH = 2;

    // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x
    localparam logic [TIME_W-1:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int                DIV100_SHIFT = 37;

    localparam logic [CODE_W-1:0] CODE_BLACK = 4'd0;
    localparam logic [CODE_W-1:0] CODE_WHITE = 4'd1;
    localparam logic [CODE_W-1:0] CODE_RED   = 4'd2;
    localparam logic [CODE_W-1:0] CODE_MAX   = 4'd8;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_STEP_DELAY = 1'b0;
    localparam logic REG_HOLD_STEPS = 1'b1;

    typedef struct packed {
        logic [DELAY_W-1:0] step_delay_ms;
        logic [HOLD_W-1:0]  hold_steps;
    } t_cfg;

    // One frame request from the front end to the LED sequencer
    typedef struct packed {
        logic                 restart;
        logic                 lit;
        logic [CYCLES_W-1:0]  cycles_pre;
        logic [LED_IDX_W-1:0] fill_pre;
        logic [LED_IDX_W-1:0] fill_post;
        logic [CODE_W-1:0]    colour;
        logic                 done;
    } t_frame_cmd;

endpackage

FILE: rtl/core/rfpa_ifs.sv
// ----------------------------------------------------------------------------
// rfpa_ifs
// Valid/ready channels for tick requests and per-LED results.
// ----------------------------------------------------------------------------
interface rfpa_in_if;
    import rfpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output operation, output now_ms, input ready);
    modport sink   (input valid, input operation, input now_ms, output ready);
endinterface

interface rfpa_out_if;
    import rfpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LED_IDX_W-1:0] led_index;
    logic [CODE_W-1:0]    color_code;
    logic                 last_in_frame;
    logic                 animation_done;

    modport source (output valid, output led_index, output color_code,
                    output last_in_frame, output animation_done, input ready);
    modport sink   (input valid, input led_index, input color_code,
                    input last_in_frame, input animation_done, output ready);
endinterface

FILE: rtl/core/rfpa_front.sv
// ----------------------------------------------------------------------------
// rfpa_front
// Accepts requests, checks the step delay, advances the animation counters
// and queues one frame request per restart or accepted step.
// ----------------------------------------------------------------------------
module rfpa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfpa_pkg::t_cfg      i_cfg,
    rfpa_in_if.sink             i_req,
    input  logic                i_queue_full,
    output logic                o_push,
    output rfpa_pkg::t_frame_cmd o_cmd
);
    import rfpa_pkg::*;

    logic [TIME_W-1:0]    r_last_step_time, n_last_step_time;
    logic [LED_IDX_W-1:0] r_rainbow_index,  n_rainbow_index;
    logic [HOLD_W-1:0]    r_hold_counter,   n_hold_counter;
    logic [LED_IDX_W-1:0] r_fill_position,  n_fill_position;
    logic [CYCLES_W-1:0]  r_cycles_done,    n_cycles_done;

    logic                 accept;
    logic                 restart;
    logic                 step;
    logic [TIME_W-1:0]    elapsed;
    logic [2*TIME_W-1:0]  div_prod;
    logic [LED_IDX_W-1:0] colour_idx;
    logic [HOLD_W-1:0]    hold_base;

    assign i_req.ready = !i_queue_full;
    assign accept      = i_req.valid && i_req.ready;
    assign restart     = accept && (i_req.operation == OP_RESTART);
    assign elapsed     = i_req.now_ms - r_last_step_time;
    assign step        = accept && (i_req.operation == OP_TICK)
                         && (elapsed >= TIME_W'(i_cfg.step_delay_ms));
    assign o_push      = restart || step;

    // Blink phase from bit 0 of now_ms / 100; product lands in the queue register
    assign div_prod   = i_req.now_ms * DIV100_MAGIC;
    assign colour_idx = (r_rainbow_index >= LED_IDX_W'(RAINBOW_COLORS))
                        ? '0 : r_rainbow_index;

    always_comb begin
        n_last_step_time = r_last_step_time;
        n_rainbow_index  = r_rainbow_index;
        n_hold_counter   = r_hold_counter;
        n_fill_position  = r_fill_position;
        n_cycles_done    = r_cycles_done;
        hold_base        = r_hold_counter;
        if (restart) begin
            n_last_step_time = '0;
            n_rainbow_index  = '0;
            n_hold_counter   = '0;
            n_fill_position  = '0;
            n_cycles_done    = '0;
        end else if (step) begin
            n_last_step_time = i_req.now_ms;
            if (r_cycles_done < CYCLES_W'(LED_COUNT)) begin
                if (r_hold_counter >= i_cfg.hold_steps) begin
                    hold_base = '0;
                    if (r_fill_position != '0) begin
                        n_fill_position = r_fill_position - 1'b1;
                    end else begin
                        // wrap the fill; after violet add one steady white LED
                        if (r_rainbow_index >= LED_IDX_W'(RAINBOW_COLORS - 1)) begin
                            n_cycles_done   = r_cycles_done + 1'b1;
                            n_rainbow_index = '0;
                        end else begin
                            n_rainbow_index = r_rainbow_index + 1'b1;
                        end
                        n_fill_position = LED_IDX_W'(LED_COUNT - 1);
                    end
                end
                n_hold_counter = hold_base + 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd.restart    = restart;
        o_cmd.lit        = !div_prod[DIV100_SHIFT];
        o_cmd.cycles_pre = r_cycles_done;
        o_cmd.fill_pre   = r_fill_position;
        o_cmd.fill_post  = n_fill_position;
        o_cmd.colour     = CODE_RED + CODE_W'(colour_idx);
        o_cmd.done       = n_cycles_done >= CYCLES_W'(LED_COUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_step_time <= '0;
            r_rainbow_index  <= '0;
            r_hold_counter   <= '0;
            r_fill_position  <= '0;
            r_cycles_done    <= '0;
        end else begin
            r_last_step_time <= n_last_step_time;
            r_rainbow_index  <= n_rainbow_index;
            r_hold_counter   <= n_hold_counter;
            r_fill_position  <= n_fill_position;
            r_cycles_done    <= n_cycles_done;
        end
    end

endmodule

FILE: rtl/core/rfpa_cmd_queue.sv
// ----------------------------------------------------------------------------
// rfpa_cmd_queue
// Short register queue of frame requests between front end and sequencer.
// ----------------------------------------------------------------------------
module rfpa_cmd_queue #(
    parameter int DEPTH = rfpa_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rfpa_pkg::t_frame_cmd i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output rfpa_pkg::t_frame_cmd o_head
);
    import rfpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_cmd       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/rfpa_back.sv
// ----------------------------------------------------------------------------
// rfpa_back
// Walks the LEDs of the frame at the queue head, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module rfpa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  rfpa_pkg::t_frame_cmd i_head,
    output logic                 o_pop,
    rfpa_out_if.source           o_res
);
    import rfpa_pkg::*;

    logic                 r_valid, n_valid;
    logic [LED_IDX_W-1:0] r_led_index, n_led_index;
    logic [CODE_W-1:0]    r_color_code, n_color_code;
    logic                 r_last, n_last;
    logic                 r_done, n_done;
    logic [LED_IDX_W-1:0] r_led_cnt, n_led_cnt;

    logic                 load;
    logic                 last_led;
    logic [CYCLES_W-1:0]  led_wide;
    logic [CODE_W-1:0]    code;

    assign load     = !r_valid || o_res.ready;
    assign last_led = (r_led_cnt == LED_IDX_W'(LED_COUNT - 1));
    assign led_wide = CYCLES_W'(r_led_cnt);
    assign o_pop    = load && !i_empty && last_led;

    always_comb begin
        code = CODE_BLACK;
        if (!i_head.restart) begin
            if (led_wide < i_head.cycles_pre) begin
                // steady white left of the fill, blinking white under it
                if (r_led_cnt >= i_head.fill_pre) begin
                    code = i_head.lit ? CODE_WHITE : CODE_BLACK;
                end else begin
                    code = CODE_WHITE;
                end
            end
            if (i_head.cycles_pre < CYCLES_W'(LED_COUNT)) begin
                if (r_led_cnt >= i_head.fill_pre && led_wide >= i_head.cycles_pre) begin
                    code = i_head.colour;
                end
                if (i_head.lit && r_led_cnt == i_head.fill_post) begin
                    code = CODE_WHITE;
                end
            end
        end
    end

    always_comb begin
        n_valid      = r_valid;
        n_led_index  = r_led_index;
        n_color_code = r_color_code;
        n_last       = r_last;
        n_done       = r_done;
        n_led_cnt    = r_led_cnt;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_led_index  = r_led_cnt;
                n_color_code = code;
                n_last       = last_led;
                n_done       = i_head.done;
                n_led_cnt    = last_led ? '0 : r_led_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_led_cnt <= '0;
        end else begin
            r_valid   <= n_valid;
            r_led_cnt <= n_led_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_led_index  <= n_led_index;
        r_color_code <= n_color_code;
        r_last       <= n_last;
        r_done       <= n_done;
    end

    assign o_res.valid          = r_valid;
    assign o_res.led_index      = r_led_index;
    assign o_res.color_code     = r_color_code;
    assign o_res.last_in_frame  = r_last;
    assign o_res.animation_done = r_done;

endmodule

FILE: rtl/core/rainbow_fill_progress_animator.sv
// ----------------------------------------------------------------------------
// rainbow_fill_progress_animator
// Rainbow fill progress animation for an eight-LED strip, one frame per restart or accepted step.
// ----------------------------------------------------------------------------
// The first LED of a frame passes through the frame queue and the registered output stage.
// The sequencer emits one LED per cycle while the output is not stalled;
//   early ticks are dropped without a frame; the frame queue absorbs two frames.
// Requests arrive back to back while the queue has room.
// Reset: synchronous, active low; clears all counters, the queue and the
//   output stage, and loads step_delay_ms = 25, hold_steps = 200.
module rainbow_fill_progress_animator #(
    parameter int QUEUE_DEPTH = rfpa_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rfpa_in_if.sink                         i_req,
    rfpa_out_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rfpa_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic       cfg_wr;
    logic       reg_sel;
    t_frame_cmd push_cmd;
    t_frame_cmd head_cmd;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (reg_sel)
                REG_STEP_DELAY: n_cfg.step_delay_ms = pwdata[DELAY_W-1:0];
                REG_HOLD_STEPS: n_cfg.hold_steps    = pwdata[HOLD_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_STEP_DELAY: prdata = APB_DATA_W'(r_cfg.step_delay_ms);
            REG_HOLD_STEPS: prdata = APB_DATA_W'(r_cfg.hold_steps);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay_ms <= DELAY_W'(25);
            r_cfg.hold_steps    <= HOLD_W'(200);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rfpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req        (i_req),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rfpa_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    rfpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/core/rfpa_checker.sv
// ----------------------------------------------------------------------------
// rfpa_checker
// Port-level checks of the animator's result stream and config port, bound to the top level.
// ----------------------------------------------------------------------------
module rfpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [rfpa_pkg::LED_IDX_W-1:0]  i_led_index,
    input logic [rfpa_pkg::CODE_W-1:0]     i_color_code,
    input logic                            i_last_in_frame,
    input logic                            i_animation_done,
    input logic                            i_pready
);
    import rfpa_pkg::*;

    // stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_led_index)
            && $stable(i_color_code) && $stable(i_last_in_frame)
            && $stable(i_animation_done))
        else $error("result changed while stalled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_last_in_frame == (i_led_index == LED_IDX_W'(LED_COUNT - 1))))
        else $error("last flag does not match LED index");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_color_code <= CODE_MAX))
        else $error("color code out of range");

    // a frame is streamed without gaps, LED by LED
    a_frame_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_last_in_frame |=> i_res_valid
            && (i_led_index == $past(i_led_index) + 1'b1)
            && (i_animation_done == $past(i_animation_done)))
        else $error("frame sequence broken");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("config port not ready");

endmodule

bind rainbow_fill_progress_animator rfpa_checker u_rfpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_led_index      (o_res.led_index),
    .i_color_code     (o_res.color_code),
    .i_last_in_frame  (o_res.last_in_frame),
    .i_animation_done (o_res.animation_done),
    .i_pready         (pready)
);

FILE: verif/tb_rainbow_fill_progress_animator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rainbow_fill_progress_animator
// Drives tick and restart requests into the animator and checks every LED
// result against a local model of the rainbow fill, across several register
// settings, random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rainbow_fill_progress_animator;
    import rfpa_pkg::*;

    localparam logic [TIME_W-1:0]     BLINK_MS        = 32'd100;
    localparam logic [APB_ADDR_W-1:0] ADDR_STEP_DELAY = {REG_STEP_DELAY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_HOLD_STEPS = {REG_HOLD_STEPS, 2'b00};
    localparam int                    HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic              op;
        logic [TIME_W-1:0] now;
    } t_tick_req;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led_index;
        logic [CODE_W-1:0]    color_code;
        logic                 last_in_frame;
        logic                 animation_done;
    } t_led_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rfpa_in_if  req_if ();
    rfpa_out_if res_if ();

    rainbow_fill_progress_animator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register shadow and animation state as the block should hold them
    logic [DELAY_W-1:0]   cfg_delay       = 16'd25;
    logic [HOLD_W-1:0]    cfg_hold        = 8'd200;
    logic [TIME_W-1:0]    anim_last_time  = '0;
    logic [2:0]           anim_colour_idx = '0;
    logic [HOLD_W-1:0]    anim_hold_cnt   = '0;
    logic [LED_IDX_W-1:0] anim_fill_pos   = '0;
    logic [CYCLES_W-1:0]  anim_cycles     = '0;

    t_tick_req   pending_reqs[$];
    t_led_result expected_leds[$];
    logic        req_taken = 1'b0;
    logic [TIME_W-1:0] gen_last;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;
    int   hold_off_left = 0;

    int mismatch_count = 0;
    int requests_taken = 0;
    int frames_built   = 0;
    int restarts_seen  = 0;
    int done_frames    = 0;
    int ticks_dropped  = 0;
    int leds_checked   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("FAIL rainbow_fill_progress_animator");
        $finish;
    end

    function automatic void advance_animation(logic op, logic [TIME_W-1:0] now);
        logic [CODE_W-1:0] codes[LED_COUNT];
        logic [TIME_W-1:0] elapsed;
        logic [CODE_W-1:0] colour;
        logic              lit;
        t_led_result       led;
        for (int i = 0; i < LED_COUNT; i++) codes[i] = CODE_BLACK;
        if (op == OP_RESTART) begin
            anim_last_time  = '0;
            anim_colour_idx = '0;
            anim_hold_cnt   = '0;
            anim_fill_pos   = '0;
            anim_cycles     = '0;
            restarts_seen++;
        end else begin
            elapsed = now - anim_last_time;
            if (elapsed < cfg_delay) begin
                ticks_dropped++;
                return;
            end
            anim_last_time = now;
            lit = ((now / BLINK_MS) % 2) == 0;
            // Completed cycles: steady white left of the fill, blinking white from it on
            for (int i = 0; i < anim_cycles && i < LED_COUNT; i++) begin
                if (i >= anim_fill_pos) begin
                    if (lit) codes[i] = CODE_WHITE;
                end else begin
                    codes[i] = CODE_WHITE;
                end
            end
            if (anim_cycles < LED_COUNT) begin
                colour = CODE_RED + anim_colour_idx;
                for (int i = anim_fill_pos; i < LED_COUNT; i++) begin
                    if (i >= anim_cycles) codes[i] = colour;
                end
                if (anim_hold_cnt >= cfg_hold) begin
                    if (anim_fill_pos > 0) begin
                        anim_fill_pos = anim_fill_pos - 1'b1;
                    end else begin
                        if (anim_colour_idx >= RAINBOW_COLORS - 1) begin
                            anim_cycles     = anim_cycles + 1'b1;
                            anim_colour_idx = '0;
                        end else begin
                            anim_colour_idx = anim_colour_idx + 1'b1;
                        end
                        anim_fill_pos = LED_IDX_W'(LED_COUNT - 1);
                    end
                    anim_hold_cnt = '0;
                end
                anim_hold_cnt = anim_hold_cnt + 1'b1;
                // Blink the fill marker at its new position
                if (lit) codes[anim_fill_pos] = CODE_WHITE;
            end
        end
        frames_built++;
        if (anim_cycles >= LED_COUNT) done_frames++;
        for (int i = 0; i < LED_COUNT; i++) begin
            led.led_index      = LED_IDX_W'(i);
            led.color_code     = codes[i];
            led.last_in_frame  = (i == LED_COUNT - 1);
            led.animation_done = (anim_cycles >= LED_COUNT);
            expected_leds.push_back(led);
        end
    endfunction

    // Request driver
    always @(negedge i_clk) begin : req_drive
        t_tick_req nxt;
        if (!i_rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.operation <= OP_TICK;
            req_if.now_ms    <= '0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_if.valid     <= 1'b1;
                req_if.operation <= nxt.op;
                req_if.now_ms    <= nxt.now;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, armed once by the stimulus
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_left <= 0;
            pressure_done <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            hold_off_left <= HOLD_OFF_CYCLES;
            pressure_done <= 1'b1;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= (hold_off_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Predict on each accepted request, check each accepted LED result
    always @(posedge i_clk) begin : led_check
        t_led_result got;
        t_led_result want;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            advance_animation(req_if.operation, req_if.now_ms);
            requests_taken++;
        end
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.led_index      = res_if.led_index;
            got.color_code     = res_if.color_code;
            got.last_in_frame  = res_if.last_in_frame;
            got.animation_done = res_if.animation_done;
            leds_checked++;
            if (expected_leds.size() == 0) begin
                mismatch_count++;
                $display({"%0t: unexpected LED result, expected none, ",
                          "got idx %0d code %0d last %0b done %0b"},
                         $time, got.led_index, got.color_code, got.last_in_frame,
                         got.animation_done);
            end else begin
                want = expected_leds.pop_front();
                if (got.led_index !== want.led_index || got.color_code !== want.color_code
                        || got.last_in_frame !== want.last_in_frame
                        || got.animation_done !== want.animation_done) begin
                    mismatch_count++;
                    $display({"%0t: LED mismatch expected idx %0d code %0d last %0b ",
                              "done %0b, got idx %0d code %0d last %0b done %0b"},
                             $time, want.led_index, want.color_code, want.last_in_frame,
                             want.animation_done, got.led_index, got.color_code,
                             got.last_in_frame, got.animation_done);
                end
            end
        end
    end

    task automatic queue_request(logic op, logic [TIME_W-1:0] now);
        t_tick_req r;
        r.op  = op;
        r.now = now;
        pending_reqs.push_back(r);
    endtask

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == ADDR_STEP_DELAY) cfg_delay = data[DELAY_W-1:0];
        else cfg_hold = data[HOLD_W-1:0];
    endtask

    task automatic wait_sent();
        while (pending_reqs.size() != 0) @(posedge i_clk);
    endtask

    // Drain all pending requests and expected LED results, then let the output stage settle
    task automatic wait_strip_idle();
        while (pending_reqs.size() != 0 || req_if.valid || expected_leds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-timed ticks from the current step time, plus early ticks,
    // random times and restarts; stop after n_items and min_steps accepted steps
    task automatic queue_fill_run(int n_items, int min_steps, int early_pct,
                                  int restart_pct, int noise_pct);
        int                issued;
        int                steps;
        int                r;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] elapsed;
        issued = 0;
        steps  = 0;
        while (issued < n_items || steps < min_steps) begin
            r = $urandom_range(99);
            if (r < restart_pct) begin
                queue_request(OP_RESTART, $urandom());
                gen_last = '0;
            end else begin
                if (r < restart_pct + noise_pct)
                    t = $urandom();
                else if (r < restart_pct + noise_pct + early_pct && cfg_delay != 0)
                    t = gen_last + $urandom_range(int'(cfg_delay) - 1, 0);
                else
                    t = gen_last + cfg_delay + $urandom_range(300, 0);
                queue_request(OP_TICK, t);
                elapsed = t - gen_last;
                if (elapsed >= cfg_delay) begin
                    gen_last = t;
                    steps++;
                end
            end
            issued++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_TICK;
        req_if.now_ms    = '0;
        res_if.ready     = 1'b0;
        tx_idle_pct      = 23;
        rx_idle_pct      = 82;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: early ticks, blink phases, time wrap, restart
        queue_request(OP_TICK, 32'd0);
        queue_request(OP_TICK, 32'd24);
        queue_request(OP_TICK, 32'd25);
        queue_request(OP_TICK, 32'd100);
        queue_request(OP_RESTART, 32'hFFFF_FFFF);
        queue_request(OP_TICK, 32'hFFFF_FFF0);
        queue_request(OP_TICK, 32'd5);
        queue_request(OP_TICK, 32'd9);
        queue_request(OP_TICK, 32'd33);
        wait_strip_idle();

        // Zero delay and zero hold: every tick steps and the fill moves each step
        reg_write(ADDR_STEP_DELAY, 32'd0);
        reg_write(ADDR_HOLD_STEPS, 32'd0);
        queue_request(OP_RESTART, 32'hFFFF_FFFF);
        queue_request(OP_TICK, 32'd0);
        queue_request(OP_TICK, 32'd0);
        queue_request(OP_TICK, 32'd0);
        queue_request(OP_TICK, 32'd150);
        queue_request(OP_TICK, 32'd150);
        queue_request(OP_TICK, 32'hFFFF_FFFF);
        queue_request(OP_TICK, 32'd200);
        queue_request(OP_RESTART, 32'h8000_0000);
        wait_strip_idle();

        // Delay and hold of one: the fill moves almost every step through several colors
        reg_write(ADDR_STEP_DELAY, 32'd1);
        reg_write(ADDR_HOLD_STEPS, 32'd1);
        gen_last = anim_last_time;
        queue_fill_run(0, 90, 5, 0, 3);
        wait_sent();
        tx_idle_pct = 82;
        rx_idle_pct = 23;
        queue_fill_run(0, 90, 5, 0, 3);
        wait_sent();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_fill_run(0, 90, 5, 0, 3);
        pressure_req = 1'b1;
        wait_strip_idle();

        // Slowest settings across the 32-bit time wrap
        reg_write(ADDR_STEP_DELAY, 32'd65535);
        reg_write(ADDR_HOLD_STEPS, 32'd255);
        tx_idle_pct = 23;
        rx_idle_pct = 82;
        queue_request(OP_TICK, 32'hFFFF_C000);
        gen_last = 32'hFFFF_C000;
        queue_fill_run(35, 0, 15, 5, 5);
        wait_strip_idle();

        reg_write(ADDR_STEP_DELAY, 32'd1000);
        reg_write(ADDR_HOLD_STEPS, 32'd2);
        tx_idle_pct = 82;
        rx_idle_pct = 23;
        gen_last = anim_last_time;
        queue_fill_run(35, 0, 15, 10, 5);
        wait_strip_idle();

        reg_write(ADDR_STEP_DELAY, $urandom_range(65535, 1));
        reg_write(ADDR_HOLD_STEPS, $urandom_range(255, 1));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        gen_last = anim_last_time;
        queue_fill_run(40, 0, 15, 8, 10);
        wait_strip_idle();
        repeat (20) @(posedge i_clk);

        $display({"Run covered %0d requests: %0d frames (%0d restarts, %0d finished), ",
                  "%0d early ticks dropped"},
                 requests_taken, frames_built, restarts_seen, done_frames, ticks_dropped);
        $display("%0d LED results checked under six register settings, %0d mismatches",
                 leds_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS rainbow_fill_progress_animator");
        end else begin
            $display("FAIL rainbow_fill_progress_animator");
        end
        $finish;
    end

endmodule
